FILE: rtl/eem_pkg.sv
package eem_pkg;

    localparam int NCLASS       = 9;
    localparam int DEF_CPUS     = 64;
    localparam int DEF_WAYS     = 8;
    localparam int DEF_CNT_BITS = 48;
    localparam int ADDR_BITS    = 64;
    localparam int DIST_BITS    = 32;

    // exit reason codes
    localparam logic [11:0] EXIT_CPUID   = 12'h072;
    localparam logic [11:0] EXIT_NPF     = 12'h400;
    localparam logic [11:0] EXIT_MSR     = 12'h07C;
    localparam logic [11:0] EXIT_SX      = 12'h05E;
    localparam logic [11:0] EXIT_DB      = 12'h041;
    localparam logic [11:0] EXIT_DF      = 12'h048;
    localparam logic [11:0] EXIT_VMMCALL = 12'h081;

    // event classes
    localparam logic [3:0] CLS_CPUID   = 4'd0;
    localparam logic [3:0] CLS_NPF     = 4'd1;
    localparam logic [3:0] CLS_MSR     = 4'd2;
    localparam logic [3:0] CLS_EOI     = 4'd3;
    localparam logic [3:0] CLS_SX      = 4'd4;
    localparam logic [3:0] CLS_DB      = 4'd5;
    localparam logic [3:0] CLS_DF      = 4'd6;
    localparam logic [3:0] CLS_VMMCALL = 4'd7;
    localparam logic [3:0] CLS_OTHER   = 4'd8;

    // commands
    localparam logic CMD_EXIT = 1'b0;
    localparam logic CMD_TRAP = 1'b1;

    // register indexes
    localparam logic [1:0] REG_STEP_AFTER_CPUID   = 2'd0;
    localparam logic [1:0] REG_STEP_BUDGET        = 2'd1;
    localparam logic [1:0] REG_FREEZE_AFTER_EXITS = 2'd2;
    localparam logic [1:0] REG_EOI_MSR_INDEX      = 2'd3;

    localparam logic [31:0] RST_STEP_BUDGET = 32'd500000;
    localparam logic [31:0] RST_EOI_MSR     = 32'h0000080B;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic        command;
        logic [5:0]  cpu_index;
        logic [11:0] exit_code;
        logic [63:0] guest_address;
        logic [31:0] msr_number;
    } item_t;

    typedef struct packed {
        logic [3:0]  event_class;
        logic [47:0] class_count;
        logic [47:0] total_count;
        logic [31:0] distinct_count;
        logic        new_address;
        logic        fresh_class;
        logic        stepping_now;
        logic        stepping_changed;
        logic        trap_consumed;
        logic        halted;
    } result_t;

    typedef struct packed {
        logic [31:0] step_after_cpuid;
        logic [31:0] step_budget;
        logic [47:0] freeze_after_exits;
        logic [31:0] eoi_msr_index;
    } cfg_t;

    function automatic logic [3:0] classify(logic [11:0] code, logic [31:0] msr,
                                            logic [31:0] eoi);
        logic [3:0] cls;
        case (code)
            EXIT_CPUID:   cls = CLS_CPUID;
            EXIT_NPF:     cls = CLS_NPF;
            EXIT_MSR:     cls = (msr == eoi) ? CLS_EOI : CLS_MSR;
            EXIT_SX:      cls = CLS_SX;
            EXIT_DB:      cls = CLS_DB;
            EXIT_DF:      cls = CLS_DF;
            EXIT_VMMCALL: cls = CLS_VMMCALL;
            default:      cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

FILE: rtl/eem_stat_ram.sv
module eem_stat_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int IDX_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             hit_reg;

    // row storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_idx];
        end
    end

    // per-row valid bits, rows never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

FILE: rtl/eem_addr_ram.sv
module eem_addr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 512,
    parameter int IDX_W = 6
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] data_reg;

    // one row holds all ways of one cpu
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = data_reg;

endmodule

FILE: rtl/eem_update.sv
module eem_update #(
    parameter int WAYS     = 8,
    parameter int CNT_BITS = 48,
    parameter int FILL_W   = 4,
    parameter int SLOT_W   = 3,
    parameter int REC_W    = 32,
    parameter int ROW_W    = 512
) (
    input  eem_pkg::item_t   item,
    input  eem_pkg::cfg_t    cfg,
    input  logic             frozen,
    input  logic             in_range,
    input  logic [REC_W-1:0] rec,
    input  logic [ROW_W-1:0] arow,
    output logic [REC_W-1:0] rec_next,
    output logic [ROW_W-1:0] arow_next,
    output logic             rec_we,
    output logic             arow_we,
    output logic             freeze_set,
    output eem_pkg::result_t res
);
    import eem_pkg::*;

    localparam int OFF_TOT  = NCLASS * CNT_BITS;
    localparam int OFF_STEP = OFF_TOT + CNT_BITS;
    localparam int OFF_DIST = OFF_STEP + CNT_BITS;
    localparam int OFF_SEEN = OFF_DIST + DIST_BITS;
    localparam int OFF_FLAG = OFF_SEEN + NCLASS;
    localparam int OFF_FILL = OFF_FLAG + 1;
    localparam int OFF_SLOT = OFF_FILL + FILL_W;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    logic [3:0]          cls;
    logic [CNT_BITS-1:0] cls_cnt;
    logic [CNT_BITS-1:0] cls_cnt_new;
    logic [CNT_BITS-1:0] cpuid_cnt_new;
    logic [CNT_BITS-1:0] total;
    logic [CNT_BITS-1:0] total_new;
    logic [CNT_BITS-1:0] steps;
    logic [CNT_BITS-1:0] steps_new;
    logic [DIST_BITS-1:0] misses;
    logic [DIST_BITS-1:0] misses_new;
    logic [NCLASS-1:0]   seen;
    logic                was;
    logic                flag_new;
    logic [FILL_W-1:0]   fill;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   slot_new;
    logic [FILL_W-1:0]   fill_new;
    logic                hit;
    logic                live;

    assign cls  = classify(item.exit_code, item.msr_number, cfg.eoi_msr_index);
    assign live = in_range && !frozen;

    // unpack the cpu record
    always_comb
    begin
        cls_cnt = '0;
        for (int k = 0; k < NCLASS; k++)
        begin
            if (cls == 4'(k))
            begin
                cls_cnt = rec[k*CNT_BITS +: CNT_BITS];
            end
        end
        total  = rec[OFF_TOT +: CNT_BITS];
        steps  = rec[OFF_STEP +: CNT_BITS];
        misses = rec[OFF_DIST +: DIST_BITS];
        seen   = rec[OFF_SEEN +: NCLASS];
        was    = rec[OFF_FLAG];
        fill   = rec[OFF_FILL +: FILL_W];
        slot   = rec[OFF_SLOT +: SLOT_W];
    end

    // saturating increments
    assign cls_cnt_new = (cls_cnt == CNT_MAX) ? cls_cnt : cls_cnt + 1'b1;
    assign total_new   = (total == CNT_MAX) ? total : total + 1'b1;

    // cpuid count after this item, used by the arming rule on cpu zero
    assign cpuid_cnt_new = (cls == CLS_CPUID) ? cls_cnt_new : rec[0 +: CNT_BITS];

    // address table lookup over the filled ways, counted as a hit while stepping
    always_comb
    begin
        hit = was;
        for (int i = 0; i < WAYS; i++)
        begin
            if ((FILL_W'(i) < fill) && (arow[i*ADDR_BITS +: ADDR_BITS] == item.guest_address))
            begin
                hit = 1'b1;
            end
        end
    end

    assign slot_new   = (slot == SLOT_W'(WAYS - 1)) ? '0 : slot + 1'b1;
    assign fill_new   = (fill < FILL_W'(WAYS)) ? fill + 1'b1 : fill;
    assign misses_new = (misses == '1) ? misses : misses + 1'b1;

    // fifo replacement of one way
    always_comb
    begin
        arow_next = arow;
        for (int j = 0; j < WAYS; j++)
        begin
            if (slot == SLOT_W'(j))
            begin
                arow_next[j*ADDR_BITS +: ADDR_BITS] = item.guest_address;
            end
        end
    end

    // record update and result
    always_comb
    begin
        rec_next   = rec;
        rec_we     = 1'b0;
        arow_we    = 1'b0;
        freeze_set = 1'b0;
        flag_new   = was;
        steps_new  = steps;
        res        = '0;
        res.halted = frozen;
        if (item.command == CMD_EXIT)
        begin
            res.event_class = cls;
        end
        if (live && item.command == CMD_TRAP)
        begin
            res.event_class = CLS_CPUID;
            if (was)
            begin
                steps_new         = (steps == CNT_MAX) ? steps : steps + 1'b1;
                res.trap_consumed = 1'b1;
                if (64'(steps_new) >= 64'(cfg.step_budget))
                begin
                    flag_new             = 1'b0;
                    res.stepping_changed = 1'b1;
                end
            end
            rec_next[OFF_STEP +: CNT_BITS] = steps_new;
            rec_next[OFF_FLAG]             = flag_new;
            rec_we                         = was;
            res.stepping_now               = flag_new;
        end
        else if (live)
        begin
            for (int k = 0; k < NCLASS; k++)
            begin
                if (cls == 4'(k))
                begin
                    rec_next[k*CNT_BITS +: CNT_BITS] = cls_cnt_new;
                end
            end
            rec_next[OFF_TOT +: CNT_BITS] = total_new;
            if (!hit)
            begin
                arow_we                         = 1'b1;
                rec_next[OFF_SLOT +: SLOT_W]    = slot_new;
                rec_next[OFF_FILL +: FILL_W]    = fill_new;
                rec_next[OFF_DIST +: DIST_BITS] = misses_new;
                res.new_address                 = 1'b1;
            end
            // nested page fault stops stepping, cpu zero arms on the cpuid count
            if (cls == CLS_NPF && was)
            begin
                flag_new             = 1'b0;
                res.stepping_changed = 1'b1;
                if (steps == '0)
                begin
                    steps_new = CNT_BITS'(1);
                end
            end
            else if (!was && steps == '0 && item.cpu_index == '0 &&
                     cfg.step_after_cpuid != '0 &&
                     64'(cpuid_cnt_new) >= 64'(cfg.step_after_cpuid))
            begin
                flag_new             = 1'b1;
                res.stepping_changed = 1'b1;
            end
            rec_next[OFF_STEP +: CNT_BITS] = steps_new;
            rec_next[OFF_FLAG]             = flag_new;
            rec_next[OFF_SEEN +: NCLASS]   = seen | (NCLASS'(1) << cls);
            rec_we                         = 1'b1;
            res.fresh_class                = !seen[cls];
            res.class_count                = 48'(cls_cnt_new);
            res.total_count                = 48'(total_new);
            res.distinct_count             = hit ? misses : misses_new;
            res.stepping_now               = flag_new;
            freeze_set = (cfg.freeze_after_exits != '0) &&
                         (64'(total_new) >= 64'(cfg.freeze_after_exits));
            res.halted = freeze_set;
        end
    end

endmodule

FILE: rtl/vm_exit_event_monitor.sv
// channel   ports                       transfer
// ------    -------------------------   -------------------------------------
// input     start, busy, item           start high and busy low at clk rise
// result    done, result                done high for one cycle, always taken
// config    wr_en, wr_index, wr_data    wr_en high at clk rise
//
// for every item the per-cpu record and address rows are read
// in the accept cycle, modified and written back in the update cycle
// the result is registered and shows in the cycle after the update cycle
// busy is high in the update cycle; a new item waits for the write-back
// reset clears row valid bits at once, so no clearing pass is needed
// the receiver cannot stall, so results never wait
module vm_exit_event_monitor #(
    parameter int CPUS         = eem_pkg::DEF_CPUS,
    parameter int TABLE_WAYS   = eem_pkg::DEF_WAYS,
    parameter int COUNTER_BITS = eem_pkg::DEF_CNT_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  eem_pkg::item_t   item,
    output logic             done,
    output eem_pkg::result_t result,
    input  logic             wr_en,
    input  logic [1:0]       wr_index,
    input  logic [47:0]      wr_data
);
    import eem_pkg::*;

    localparam int CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int SLOT_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int FILL_W = $clog2(TABLE_WAYS + 1);
    localparam int REC_W  = (NCLASS + 2) * COUNTER_BITS + DIST_BITS + NCLASS + 1
                            + FILL_W + SLOT_W;
    localparam int ROW_W  = TABLE_WAYS * ADDR_BITS;

    state_t            state_reg;
    state_t            state_next;
    item_t             item_reg;
    cfg_t              cfg_reg;
    logic              frozen_reg;
    logic              done_reg;
    result_t           result_reg;
    logic              accept;
    logic              upd_go;
    logic [8:0]        cpu_ext;
    logic [8:0]        cpu_ext_reg;
    logic              in_range;
    logic [REC_W-1:0]  rec;
    logic [REC_W-1:0]  rec_next;
    logic [ROW_W-1:0]  arow;
    logic [ROW_W-1:0]  arow_next;
    logic              rec_we;
    logic              arow_we;
    logic              freeze_set;
    result_t           res;

    assign accept      = start && !busy;
    assign cpu_ext     = {3'b000, item.cpu_index};
    assign cpu_ext_reg = {3'b000, item_reg.cpu_index};
    assign in_range    = cpu_ext_reg < 9'(CPUS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_UPDATE : ST_IDLE;
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            ST_UPDATE:
            begin
                busy   = 1'b1;
                upd_go = 1'b1;
            end
            default:
            begin
                busy   = 1'b0;
                upd_go = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            frozen_reg <= 1'b0;
            done_reg   <= 1'b0;
            cfg_reg.step_after_cpuid   <= '0;
            cfg_reg.step_budget        <= RST_STEP_BUDGET;
            cfg_reg.freeze_after_exits <= '0;
            cfg_reg.eoi_msr_index      <= RST_EOI_MSR;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= upd_go;
            if (upd_go && freeze_set)
            begin
                frozen_reg <= 1'b1;
            end
            if (wr_en)
            begin
                case (wr_index)
                    REG_STEP_AFTER_CPUID:   cfg_reg.step_after_cpuid   <= wr_data[31:0];
                    REG_STEP_BUDGET:        cfg_reg.step_budget        <= wr_data[31:0];
                    REG_FREEZE_AFTER_EXITS: cfg_reg.freeze_after_exits <= wr_data;
                    REG_EOI_MSR_INDEX:      cfg_reg.eoi_msr_index      <= wr_data[31:0];
                    default:                cfg_reg.eoi_msr_index      <= cfg_reg.eoi_msr_index;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (upd_go)
        begin
            result_reg <= res;
        end
    end

    eem_stat_ram #(
        .DEPTH (CPUS),
        .WIDTH (REC_W),
        .IDX_W (CPU_W)
    ) u_stat (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (cpu_ext[CPU_W-1:0]),
        .rd_data (rec),
        .wr_en   (upd_go && rec_we),
        .wr_idx  (cpu_ext_reg[CPU_W-1:0]),
        .wr_data (rec_next)
    );

    eem_addr_ram #(
        .DEPTH (CPUS),
        .WIDTH (ROW_W),
        .IDX_W (CPU_W)
    ) u_addr (
        .clk     (clk),
        .rd_en   (accept),
        .rd_idx  (cpu_ext[CPU_W-1:0]),
        .rd_data (arow),
        .wr_en   (upd_go && arow_we),
        .wr_idx  (cpu_ext_reg[CPU_W-1:0]),
        .wr_data (arow_next)
    );

    eem_update #(
        .WAYS     (TABLE_WAYS),
        .CNT_BITS (COUNTER_BITS),
        .FILL_W   (FILL_W),
        .SLOT_W   (SLOT_W),
        .REC_W    (REC_W),
        .ROW_W    (ROW_W)
    ) u_update (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .frozen     (frozen_reg),
        .in_range   (in_range),
        .rec        (rec),
        .arow       (arow),
        .rec_next   (rec_next),
        .arow_next  (arow_next),
        .rec_we     (rec_we),
        .arow_we    (arow_we),
        .freeze_set (freeze_set),
        .res        (res)
    );

    assign done   = done_reg;
    assign result = result_reg;

    // a result always follows an update cycle
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE))
        else $error("result without update cycle");

    // an accepted item always goes to its update cycle
    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted item not updated");

    // no new read while a write-back is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> !accept)
        else $error("read overlaps write-back");

    // freeze is permanent
    a_frozen_stays: assert property (@(posedge clk) disable iff (!rst_n)
        frozen_reg |=> frozen_reg)
        else $error("frozen state cleared");

endmodule
